// ===== design/emaa_pkg.sv =====
// ----------------------------------------------------------------------------
// emaa_pkg
// Shared widths, register codes and scaling constants of the multi-turn
// encoder angle accumulator.
// ----------------------------------------------------------------------------
package emaa_pkg;

  // field widths
  localparam int ANGLE_W   = 13;
  localparam int SPEED_W   = 16;
  localparam int ACCUM_W   = 56;
  localparam int TOTAL_W   = 56;
  localparam int CFG_IDX_W = 8;
  localparam int CFG_DAT_W = 16;

  // encoder and gearbox
  localparam longint unsigned ENC_MOD       = 64'd8191;
  localparam longint unsigned GEAR_SLOW     = 64'd19;
  localparam longint unsigned GEAR_FAST     = 64'd36;
  localparam longint unsigned FULL_TURN_DEG = 64'd360;
  localparam int              FRAC_BITS     = 24;
  localparam logic [ANGLE_W-1:0] WRAP_LIMIT_RST = ANGLE_W'(1250);

  // step magnitude in counts and the scaled increment
  localparam int MAG_W   = ANGLE_W;
  localparam int QI_W    = 16;
  localparam int DEN_W   = 19;
  localparam int Y_W     = 32;
  localparam int Q_W     = 30;
  localparam int RECIP_W = 34;
  localparam int RECIP_SHIFT = Y_W + DEN_W;
  localparam int PROD_W  = Y_W + RECIP_W;

  // degrees per count in q.24 split as whole part plus remainder over den
  localparam longint unsigned SCALE_NUM = FULL_TURN_DEG * (64'd1 << FRAC_BITS);
  localparam longint unsigned DEN_SLOW  = ENC_MOD * GEAR_SLOW;
  localparam longint unsigned DEN_FAST  = ENC_MOD * GEAR_FAST;

  localparam logic [QI_W-1:0]  QI_SLOW   = QI_W'(SCALE_NUM / DEN_SLOW);
  localparam logic [QI_W-1:0]  QI_FAST   = QI_W'(SCALE_NUM / DEN_FAST);
  localparam logic [DEN_W-1:0] REM_SLOW  = DEN_W'(SCALE_NUM % DEN_SLOW);
  localparam logic [DEN_W-1:0] REM_FAST  = DEN_W'(SCALE_NUM % DEN_FAST);
  localparam logic [DEN_W-1:0] HALF_SLOW = DEN_W'(DEN_SLOW / 64'd2);
  localparam logic [DEN_W-1:0] HALF_FAST = DEN_W'(DEN_FAST / 64'd2);

  // rounded-up reciprocals, exact floor division for any 32-bit dividend
  localparam logic [RECIP_W-1:0] RECIP_SLOW =
    RECIP_W'(((64'd1 << RECIP_SHIFT) + DEN_SLOW - 64'd1) / DEN_SLOW);
  localparam logic [RECIP_W-1:0] RECIP_FAST =
    RECIP_W'(((64'd1 << RECIP_SHIFT) + DEN_FAST - 64'd1) / DEN_FAST);

  // saturation bounds
  localparam logic signed [ACCUM_W-1:0] ACCUM_MAX = {1'b0, {(ACCUM_W-1){1'b1}}};
  localparam logic signed [ACCUM_W-1:0] ACCUM_MIN = {1'b1, {(ACCUM_W-1){1'b0}}};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MOTOR_KIND = 8'd0,
    REG_WRAP_LIMIT = 8'd1
  } cfg_reg_e;

  typedef enum logic {
    MOTOR_SLOW_GEAR = 1'b0,
    MOTOR_FAST_GEAR = 1'b1
  } motor_kind_e;

endpackage

// ===== design/emaa_intf.sv =====
// ----------------------------------------------------------------------------
// emaa channel interfaces
// Valid/ready channels for encoder samples, accumulated results and
// register writes.
// ----------------------------------------------------------------------------
interface emaa_sample_if import emaa_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic        [ANGLE_W-1:0] enc_angle;
  logic signed [SPEED_W-1:0] enc_speed;

  modport source (output valid, output enc_angle, output enc_speed, input ready);
  modport sink   (input valid, input enc_angle, input enc_speed, output ready);
endinterface

interface emaa_result_if import emaa_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [TOTAL_W-1:0] total_angle;
  logic                      step_taken;

  modport source (output valid, output total_angle, output step_taken, input ready);
  modport sink   (input valid, input total_angle, input step_taken, output ready);
endinterface

interface emaa_cfg_if import emaa_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DAT_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== design/encoder_multiturn_angle_accumulator_core.sv =====
// ----------------------------------------------------------------------------
// encoder_multiturn_angle_accumulator_core
// Unwraps absolute rotor encoder samples into a saturating multi-turn
// output-shaft angle in degrees, q.24.
// ----------------------------------------------------------------------------
//  channel   dir   handshake     payload
//  sample_i  in    valid/ready   enc_angle[12:0], enc_speed[15:0] signed
//  result_o  out   valid/ready   total_angle[55:0] signed, step_taken
//  cfg_i     in    valid/ready   index[7:0], data[15:0]; always ready
//
//  one sample per cycle sustained while result_o is ready; the result is registered after the stages below
//  stages: step unwrap -> scale products -> reciprocal divide -> accumulate
//  the saturating add into the accumulator is the only feedback loop
//  each stage holds when the next is full, so bubbles fill under output stall
//  reset: pipeline empty, not primed, total 0, motor_kind 0, wrap_limit 1250
// ----------------------------------------------------------------------------
module encoder_multiturn_angle_accumulator_core import emaa_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  emaa_cfg_if.sink      cfg_i,
  emaa_sample_if.sink   sample_i,
  emaa_result_if.source result_o
);

  // configuration
  motor_kind_e        motor_kind_q;
  logic [ANGLE_W-1:0] wrap_limit_q;

  // unwrap state
  logic [ANGLE_W-1:0] prev_angle_q;
  logic               primed_q;

  // pipeline valids
  logic va_q, vb_q, vc_q, vo_q;
  logic adv_a, adv_b, adv_c;
  logic a_free, b_free, c_free, o_free;
  logic in_acc;

  // stage payloads
  logic [MAG_W-1:0] m_d, m_a_q;
  logic             rev_a_q, taken_a_q;
  logic [Q_W-1:0]   p_int_d, p_int_b_q;
  logic [Y_W-1:0]   y_d, y_b_q;
  logic             rev_b_q, taken_b_q;
  logic [Q_W-1:0]   q_d, q_c_q;
  logic             rev_c_q, taken_c_q;

  logic signed [ACCUM_W-1:0] acc_q, acc_d;
  logic                      taken_o_q;

  // stage a comb
  logic               rev_in;
  logic               wrap_case;
  logic [ANGLE_W-1:0] ang_in;
  logic [ANGLE_W-1:0] diff_fwd, diff_rev, wrap_w;

  // stage b/c selections
  logic [QI_W-1:0]    qi_sel;
  logic [DEN_W-1:0]   rem_sel, half_sel;
  logic [RECIP_W-1:0] recip_sel;
  logic [PROD_W-1:0]  div_prod;

  // accumulate
  logic signed [ACCUM_W:0] inc, sum;

  // ---------------------------------------------------------------------------
  // configuration writes
  // ---------------------------------------------------------------------------
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      motor_kind_q <= MOTOR_SLOW_GEAR;
      wrap_limit_q <= WRAP_LIMIT_RST;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        REG_MOTOR_KIND: motor_kind_q <= motor_kind_e'(cfg_i.data[0]);
        REG_WRAP_LIMIT: wrap_limit_q <= cfg_i.data[ANGLE_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // handshake and stage advance
  // ---------------------------------------------------------------------------
  assign o_free = !vo_q || result_o.ready;
  assign adv_c  = vc_q && o_free;
  assign c_free = !vc_q || adv_c;
  assign adv_b  = vb_q && c_free;
  assign b_free = !vb_q || adv_b;
  assign adv_a  = va_q && b_free;
  assign a_free = !va_q || adv_a;

  assign sample_i.ready = a_free;
  assign in_acc         = sample_i.valid && a_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      if (a_free) begin
        va_q <= sample_i.valid;
      end
      if (b_free) begin
        vb_q <= adv_a;
      end
      if (c_free) begin
        vc_q <= adv_b;
      end
      if (o_free) begin
        vo_q <= adv_c;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stage a: unwrap to a step magnitude in the speed direction
  // ---------------------------------------------------------------------------
  assign ang_in   = sample_i.enc_angle;
  assign rev_in   = sample_i.enc_speed[SPEED_W-1];
  assign diff_fwd = ang_in - prev_angle_q;
  assign diff_rev = prev_angle_q - ang_in;
  assign wrap_case = rev_in ? (ang_in > prev_angle_q) : (ang_in < prev_angle_q);
  // distance the other way round the circle
  assign wrap_w   = ANGLE_W'(ENC_MOD) - (rev_in ? diff_fwd : diff_rev);

  always_comb begin
    m_d = '0;
    if (primed_q) begin
      if (wrap_case) begin
        m_d = (wrap_w < wrap_limit_q) ? wrap_w : '0;
      end else begin
        m_d = rev_in ? diff_rev : diff_fwd;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_angle_q <= '0;
      primed_q     <= 1'b0;
    end else if (in_acc) begin
      prev_angle_q <= ang_in;
      primed_q     <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      m_a_q     <= m_d;
      rev_a_q   <= rev_in;
      taken_a_q <= (m_d != '0);
    end
  end

  // ---------------------------------------------------------------------------
  // stage b: whole part m*qi and dividend m*rem + den/2
  // ---------------------------------------------------------------------------
  always_comb begin
    if (motor_kind_q == MOTOR_FAST_GEAR) begin
      qi_sel    = QI_FAST;
      rem_sel   = REM_FAST;
      half_sel  = HALF_FAST;
      recip_sel = RECIP_FAST;
    end else begin
      qi_sel    = QI_SLOW;
      rem_sel   = REM_SLOW;
      half_sel  = HALF_SLOW;
      recip_sel = RECIP_SLOW;
    end
  end

  assign p_int_d = Q_W'(m_a_q) * Q_W'(qi_sel);
  assign y_d     = Y_W'(m_a_q) * Y_W'(rem_sel) + Y_W'(half_sel);

  always_ff @(posedge clk_i) begin
    if (adv_a) begin
      p_int_b_q <= p_int_d;
      y_b_q     <= y_d;
      rev_b_q   <= rev_a_q;
      taken_b_q <= taken_a_q;
    end
  end

  // ---------------------------------------------------------------------------
  // stage c: rounded fraction by reciprocal multiply, added to whole part
  // ---------------------------------------------------------------------------
  assign div_prod = PROD_W'(y_b_q) * PROD_W'(recip_sel);
  assign q_d      = p_int_b_q + Q_W'(div_prod[RECIP_SHIFT +: MAG_W]);

  always_ff @(posedge clk_i) begin
    if (adv_b) begin
      q_c_q     <= q_d;
      rev_c_q   <= rev_b_q;
      taken_c_q <= taken_b_q;
    end
  end

  // ---------------------------------------------------------------------------
  // output stage: saturating accumulate
  // ---------------------------------------------------------------------------
  always_comb begin
    inc = (ACCUM_W+1)'(q_c_q);
    if (rev_c_q) begin
      inc = -inc;
    end
    sum   = {acc_q[ACCUM_W-1], acc_q} + inc;
    acc_d = sum[ACCUM_W-1:0];
    if (sum[ACCUM_W] != sum[ACCUM_W-1]) begin
      acc_d = sum[ACCUM_W] ? ACCUM_MIN : ACCUM_MAX;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else if (adv_c && taken_c_q) begin
      acc_q <= acc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_c) begin
      taken_o_q <= taken_c_q;
    end
  end

  assign result_o.valid       = vo_q;
  assign result_o.total_angle = TOTAL_W'(acc_q);
  assign result_o.step_taken  = taken_o_q;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  a_acc_only_on_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv_c |=> $stable(acc_q))
    else $error("accumulator changed without a result load");

  a_first_sample_no_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && !primed_q |-> m_d == '0)
    else $error("priming sample produced a step");

  a_wrap_within_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && primed_q && wrap_case |-> (m_d == '0) || (m_d < wrap_limit_q))
    else $error("wrap step at or above limit accepted");

  a_taken_nonzero_inc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vc_q && taken_c_q |-> q_c_q != '0)
    else $error("taken step scaled to zero");

endmodule

// ===== sim/tb_encoder_multiturn_angle_accumulator_core.sv =====
// ----------------------------------------------------------------------------
// tb_encoder_multiturn_angle_accumulator_core
// Drives encoder samples and register writes into the multi-turn angle
// accumulator and checks every result against a cycle-free model of the
// unwrap, wrap rejection, sign filter, q.24 scaling and saturating total.
// ----------------------------------------------------------------------------
module tb_encoder_multiturn_angle_accumulator_core;
  import emaa_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int     SETTLE_CYCLES  = 8;
  localparam int     HOLDOFF_CYCLES = 80;
  localparam longint TIMEOUT_NS     = 64'd4_000_000;
  localparam longint TOTAL_HI       = (64'sd1 <<< (ACCUM_W - 1)) - 64'sd1;
  localparam longint TOTAL_LO       = -TOTAL_HI - 64'sd1;
  localparam longint MODULUS        = longint'(ENC_MOD);

  typedef struct {
    logic signed [TOTAL_W-1:0] total;
    logic                      taken;
  } total_rec_t;

  // tracks the multi-turn total the block should report
  class turn_tracker;
    motor_kind_e        kind;
    int                 wrap_lim;
    logic [ANGLE_W-1:0] prev_angle;
    bit                 primed;
    longint             total;
    total_rec_t         expected_totals[$];
    int                 errors;

    function new();
      kind       = MOTOR_SLOW_GEAR;
      wrap_lim   = int'(WRAP_LIMIT_RST);
      prev_angle = '0;
      primed     = 1'b0;
      total      = 0;
      errors     = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] dat);
      case (idx)
        REG_MOTOR_KIND: kind = motor_kind_e'(dat[0]);
        REG_WRAP_LIMIT: wrap_lim = int'(dat[ANGLE_W-1:0]);
        default: ;
      endcase
    endfunction

    // q.24 degrees for a step in counts, nearest with ties away from zero
    function longint degrees_q24(longint counts);
      longint unsigned den, mag, q;
      den = ENC_MOD * ((kind == MOTOR_FAST_GEAR) ? GEAR_FAST : GEAR_SLOW);
      mag = (counts < 0) ? -counts : counts;
      q   = (mag * FULL_TURN_DEG * (64'd1 << FRAC_BITS) + den / 64'd2) / den;
      return (counts < 0) ? -longint'(q) : longint'(q);
    endfunction

    function void note_sample(logic [ANGLE_W-1:0] ang, logic signed [SPEED_W-1:0] spd);
      longint     a, p, w, mw, stp, inc;
      bit         rev, taken;
      total_rec_t rec;
      a     = longint'(ang);
      p     = longint'(prev_angle);
      rev   = spd[SPEED_W-1];
      stp   = 0;
      taken = 1'b0;
      if (!primed) begin
        primed = 1'b1;
      end else begin
        if (!rev && a < p) begin
          w   = MODULUS + a - p;
          mw  = (w < 0) ? -w : w;
          stp = (mw < wrap_lim) ? w : 0;
        end else if (rev && a > p) begin
          w   = MODULUS - a + p;
          mw  = (w < 0) ? -w : w;
          stp = (mw < wrap_lim) ? -w : 0;
        end else begin
          stp = a - p;
        end
        if ((!rev && stp > 0) || (rev && stp < 0)) begin
          inc = degrees_q24(stp);
          if (inc > 0) begin
            total = (total > TOTAL_HI - inc) ? TOTAL_HI : total + inc;
          end else if (inc < 0) begin
            total = (total < TOTAL_LO - inc) ? TOTAL_LO : total + inc;
          end
          taken = 1'b1;
        end
      end
      prev_angle = ang;
      rec.total  = total[TOTAL_W-1:0];
      rec.taken  = taken;
      expected_totals.push_back(rec);
    endfunction

    function void check_total(logic signed [TOTAL_W-1:0] got_total, logic got_taken);
      total_rec_t rec;
      if (expected_totals.size() == 0) begin
        $display("%0t: unexpected result total_angle=%0d step_taken=%0b",
                 $time, got_total, got_taken);
        errors++;
        return;
      end
      rec = expected_totals.pop_front();
      if (got_total !== rec.total) begin
        $display("%0t: total_angle mismatch expected %0d actual %0d",
                 $time, rec.total, got_total);
        errors++;
      end
      if (got_taken !== rec.taken) begin
        $display("%0t: step_taken mismatch expected %0b actual %0b",
                 $time, rec.taken, got_taken);
        errors++;
      end
    endfunction

    function int pending();
      return expected_totals.size();
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;

  emaa_cfg_if    cfg_ch();
  emaa_sample_if smp_ch();
  emaa_result_if res_ch();

  encoder_multiturn_angle_accumulator_core DUT (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_ch),
    .sample_i (smp_ch),
    .result_o (res_ch)
  );

  turn_tracker tracker = new();

  int gap_pct;
  int stall_pct;
  bit holdoff_req;
  int track;

  always #5 clk_i = ~clk_i;

  // result side: ready decided at the falling edge, long hold-off on request
  initial begin
    forever begin
      @(negedge clk_i);
      if (holdoff_req) begin
        holdoff_req = 1'b0;
        res_ch.ready <= 1'b0;
        repeat (HOLDOFF_CYCLES - 1) begin
          @(negedge clk_i);
          res_ch.ready <= 1'b0;
        end
      end else begin
        res_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && res_ch.valid && res_ch.ready) begin
      tracker.check_total(res_ch.total_angle, res_ch.step_taken);
    end
  end

  initial begin
    #(TIMEOUT_NS);
    $display("CHECKS FAILED");
    $finish;
  end

  // called at a falling edge, returns at the falling edge after the accept
  task automatic push_sample(input logic [ANGLE_W-1:0] ang,
                             input logic signed [SPEED_W-1:0] spd);
    while ($urandom_range(0, 99) < gap_pct) begin
      smp_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    smp_ch.valid     <= 1'b1;
    smp_ch.enc_angle <= ang;
    smp_ch.enc_speed <= spd;
    do @(posedge clk_i); while (!smp_ch.ready);
    tracker.note_sample(ang, spd);
    @(negedge clk_i);
  endtask

  task automatic sample_idle();
    smp_ch.valid <= 1'b0;
    @(negedge clk_i);
  endtask

  // stop offering items and wait until every result is back
  task automatic drain();
    sample_idle();
    while (tracker.pending() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] dat);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= dat;
    do @(posedge clk_i); while (!cfg_ch.ready);
    tracker.write_reg(idx, dat);
    @(negedge clk_i);
    cfg_ch.valid <= 1'b0;
    @(negedge clk_i);
  endtask

  // mostly runs of steps in one direction with the speed sign to match,
  // mixed with unrelated angles and speeds
  task automatic stream_items(input int count);
    int                        left, run_len, stp, step_max;
    bit                        rev;
    logic signed [SPEED_W-1:0] spd;
    left = count;
    while (left > 0) begin
      if ($urandom_range(0, 99) < 20) begin
        push_sample(ANGLE_W'($urandom_range(0, 8191)), SPEED_W'($urandom));
        left--;
      end else begin
        run_len  = $urandom_range(3, 24);
        rev      = $urandom_range(0, 1);
        step_max = ($urandom_range(0, 3) == 0) ? 8190 : 700;
        for (int i = 0; i < run_len && left > 0; i++) begin
          stp = $urandom_range(0, step_max);
          if ($urandom_range(0, 49) == 0) begin
            track = 8191;
          end else if (rev) begin
            track = (track + 8191 - stp) % 8191;
          end else begin
            track = (track + stp) % 8191;
          end
          spd = rev ? SPEED_W'(-$urandom_range(1, 32768)) : SPEED_W'($urandom_range(0, 32767));
          push_sample(ANGLE_W'(track), spd);
          left--;
        end
      end
    end
  endtask

  initial begin
    int          wl;
    motor_kind_e kind;
    rst_ni           = 1'b0;
    cfg_ch.valid     = 1'b0;
    cfg_ch.index     = '0;
    cfg_ch.data      = '0;
    smp_ch.valid     = 1'b0;
    smp_ch.enc_angle = '0;
    smp_ch.enc_speed = '0;
    res_ch.ready     = 1'b0;
    gap_pct          = 0;
    stall_pct        = 0;
    holdoff_req      = 1'b0;
    track            = 0;
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // reset settings: slow gear, wrap limit 1250
    push_sample(13'd100,  16'h0000);  // priming
    push_sample(13'd100,  16'h0005);  // zero step
    push_sample(13'd600,  16'h7FFF);
    push_sample(13'd8190, 16'h0001);  // large forward step
    push_sample(13'd50,   16'h0001);  // small forward wrap
    push_sample(13'd30,   16'h0001);  // wrap too large
    push_sample(13'd20,   16'hFFFF);
    push_sample(13'd8000, 16'h8000);  // small reverse wrap
    push_sample(13'd8100, 16'hFFFB);
    push_sample(13'd8191, 16'h0003);  // angle outside the modulus
    push_sample(13'd0,    16'h0003);  // zero-length wrap
    push_sample(13'd8191, 16'hFFFD);
    push_sample(13'd1249, 16'h0000);  // wrap one below the limit
    push_sample(13'd8000, 16'h0000);
    push_sample(13'd1059, 16'h0000);  // wrap exactly at the limit
    push_sample(13'd8000, 16'h0000);
    push_sample(13'd1058, 16'h0000);
    push_sample(13'd1058, 16'h8000);
    push_sample(13'd2309, 16'hFFFF);
    push_sample(13'd2000, 16'hFFFF);
    push_sample(13'd3000, 16'hFFFF);
    push_sample(13'd0,    16'h7FFF);
    push_sample(13'd6942, 16'hFFFF);
    push_sample(13'd0,    16'h0000);
    push_sample(13'd6941, 16'h8000);

    stream_items(100);
    holdoff_req = 1'b1;
    stream_items(100);

    for (int ph = 1; ph < 8; ph++) begin
      drain();
      kind = motor_kind_e'(ph % 2);
      case (ph)
        1, 6:    wl = 8191;
        2:       wl = 0;
        3:       wl = 1;
        5:       wl = 1250;
        default: wl = $urandom_range(1, 2500);
      endcase
      write_reg(REG_MOTOR_KIND, {15'($urandom), 1'(kind)});
      write_reg(REG_WRAP_LIMIT, {3'($urandom), 13'(wl)});
      if (ph == 3) begin
        write_reg(CFG_IDX_W'($urandom_range(2, 255)), CFG_DAT_W'($urandom));
      end
      case (ph % 4)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 64; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 64; end
        default: begin gap_pct = 12; stall_pct = 12; end
      endcase
      stream_items(100);
      if (ph == 4 || ph == 7) begin
        holdoff_req = 1'b1;
      end
      if (ph == 2 || ph == 5) begin
        drain();
      end
      stream_items(105);
    end

    gap_pct   = 0;
    stall_pct = 0;
    drain();
    if (tracker.pending() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, tracker.pending());
      tracker.errors++;
    end
    if (tracker.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
